>>> src/assert_macros.svh
// Assertion macros used by the RTL of the timer/event counter.
// No dependencies; the bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// cond must hold at every clock edge out of reset
`define ASSERT_HOLDS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
// ante in a cycle implies cons in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// ante in a cycle implies cons in the next cycle
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_HOLDS(lbl, cond)
`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> src/ptec_pkg.sv
// Types and constants of the prescaled timer/event counter.
// No dependencies.
package ptec_pkg;

    localparam int PRESCALE_BITS = 5;
    localparam int COUNT_BITS    = 8;
    localparam int SAMPLE_BITS   = 8;
    localparam int CYCLE_BITS    = 4;

    typedef enum logic [3:0] {
        CMD_TICK          = 4'd0,
        CMD_START_TIMER   = 4'd1,
        CMD_START_COUNTER = 4'd2,
        CMD_STOP          = 4'd3,
        CMD_LOAD          = 4'd4,
        CMD_READ          = 4'd5,
        CMD_TEST_CLEAR    = 4'd6,
        CMD_IRQ_ENABLE    = 4'd7,
        CMD_IRQ_DISABLE   = 4'd8,
        CMD_IRQ_TAKEN     = 4'd9
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_STOP    = 2'd0,
        MODE_TIMER   = 2'd1,
        MODE_COUNTER = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_RUN  = 2'd1,
        ST_DONE = 2'd2
    } state_t;

endpackage

>>> src/prescaled_timer_event_counter.sv
// Prescaled 8-bit timer / event counter: one command per transfer, one result per command.
// Depends on ptec_pkg and assert_macros.svh.
//
//  channel | signals                                        | dir
//  --------+------------------------------------------------+-----
//  in      | in_valid, in_ready, cmd, tick_cycles,          | in
//          | t1_samples, load_value                         |
//  out     | out_valid, out_ready, timer_value, flag_seen,  | out
//          | irq_request                                    |
//
// A command passes through the RUN and DONE states from its transfer to its result;
// a tick in counter mode stays in RUN for each sampled T1 cycle (capped at MAX_TICK): the
// shared 8-bit incrementer takes one pin sample per clock.
// in_ready is high only while the sequencer is idle; a finished result waits in
// the output register, and the next command is taken meanwhile.
// Reset clears all timer state; no clearing pass is needed.
`include "assert_macros.svh"

module prescaled_timer_event_counter
    import ptec_pkg::*;
#(
    parameter int MAX_TICK = 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [3:0]               cmd,
    input  logic [CYCLE_BITS-1:0]    tick_cycles,
    input  logic [SAMPLE_BITS-1:0]   t1_samples,
    input  logic [COUNT_BITS-1:0]    load_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [COUNT_BITS-1:0]    timer_value,
    output logic                     flag_seen,
    output logic                     irq_request
);

    localparam logic [CYCLE_BITS:0] MaxTickW = (CYCLE_BITS+1)'(MAX_TICK);

    state_t state_reg, state_next;

    logic [3:0]               cmd_reg, cmd_next;
    logic [CYCLE_BITS-1:0]    cyc_reg, cyc_next;
    logic [CYCLE_BITS-1:0]    step_reg, step_next;
    logic [SAMPLE_BITS-1:0]   samp_reg, samp_next;
    logic [COUNT_BITS-1:0]    load_reg, load_next;

    logic [COUNT_BITS-1:0]    count_reg, count_next;
    logic [PRESCALE_BITS-1:0] pre_reg, pre_next;
    mode_t                    mode_reg, mode_next;
    logic                     last_reg, last_next;
    logic                     flag_reg, flag_next;
    logic                     ien_reg, ien_next;
    logic                     pend_reg, pend_next;
    logic                     seen_reg, seen_next;

    logic                     out_valid_reg, out_valid_next;
    logic [COUNT_BITS-1:0]    tv_reg, tv_next;
    logic                     fs_reg, fs_next;
    logic                     irq_reg, irq_next;

    // sequencer controls
    logic accept;
    logic run_active;
    logic loop_busy;
    logic out_load;

    // shared incrementer
    logic                     inc_en;
    logic [COUNT_BITS-1:0]    inc_sum;
    logic                     wrap;

    logic [PRESCALE_BITS:0]   pre_sum;
    logic [2:0]               samp_idx;
    logic                     level;
    logic [CYCLE_BITS-1:0]    cyc_sat;

    assign accept   = in_valid && in_ready;
    assign pre_sum  = {1'b0, pre_reg} + (PRESCALE_BITS+1)'(cyc_reg);
    assign samp_idx = (step_reg < CYCLE_BITS'(SAMPLE_BITS)) ? step_reg[2:0] : 3'd7;
    assign level    = samp_reg[samp_idx];
    assign inc_sum  = count_reg + COUNT_BITS'(1);
    assign wrap     = inc_en && (count_reg == {COUNT_BITS{1'b1}});
    assign cyc_sat  = ({1'b0, tick_cycles} > MaxTickW) ? MaxTickW[CYCLE_BITS-1:0]
                                                      : tick_cycles;

    // counter-mode tick walks the samples one per clock
    assign loop_busy = (cmd_reg == CMD_TICK) && (mode_reg == MODE_COUNTER)
                       && (step_reg != cyc_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (!loop_busy)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready   = 1'b0;
        run_active = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: in_ready   = 1'b1;
            ST_RUN:  run_active = 1'b1;
            ST_DONE: out_load   = !out_valid_reg || out_ready;
            default: in_ready   = 1'b0;
        endcase
    end

    // command latch
    always_comb
    begin
        cmd_next  = cmd_reg;
        cyc_next  = cyc_reg;
        samp_next = samp_reg;
        load_next = load_reg;
        if (accept)
        begin
            cmd_next  = cmd;
            cyc_next  = cyc_sat;
            samp_next = t1_samples;
            load_next = load_value;
        end
    end

    // timer state update
    always_comb
    begin
        count_next = count_reg;
        pre_next   = pre_reg;
        mode_next  = mode_reg;
        last_next  = last_reg;
        flag_next  = flag_reg;
        ien_next   = ien_reg;
        pend_next  = pend_reg;
        seen_next  = seen_reg;
        step_next  = step_reg;
        inc_en     = 1'b0;

        if (accept)
        begin
            step_next = '0;
            seen_next = 1'b0;
        end

        if (run_active)
        begin
            case (cmd_reg)
                CMD_TICK:
                begin
                    case (mode_reg)
                        MODE_TIMER:
                        begin
                            pre_next = pre_sum[PRESCALE_BITS-1:0];
                            inc_en   = pre_sum[PRESCALE_BITS];
                        end
                        MODE_COUNTER:
                        begin
                            if (loop_busy)
                            begin
                                inc_en    = last_reg && !level;
                                last_next = level;
                                step_next = step_reg + CYCLE_BITS'(1);
                            end
                        end
                        default: inc_en = 1'b0;
                    endcase
                end
                CMD_START_TIMER:
                begin
                    mode_next = MODE_TIMER;
                    pre_next  = '0;
                end
                CMD_START_COUNTER:
                begin
                    // keep the pin history when already counting
                    if (mode_reg != MODE_COUNTER)
                        last_next = samp_reg[0];
                    mode_next = MODE_COUNTER;
                end
                CMD_STOP:        mode_next  = MODE_STOP;
                CMD_LOAD:        count_next = load_reg;
                CMD_TEST_CLEAR:
                begin
                    seen_next = flag_reg;
                    flag_next = 1'b0;
                end
                CMD_IRQ_ENABLE:  ien_next = 1'b1;
                CMD_IRQ_DISABLE:
                begin
                    ien_next  = 1'b0;
                    pend_next = 1'b0;
                end
                CMD_IRQ_TAKEN:   pend_next = 1'b0;
                default:         seen_next = 1'b0;
            endcase

            if (inc_en)
                count_next = inc_sum;
            if (wrap)
            begin
                flag_next = 1'b1;
                if (ien_reg)
                    pend_next = 1'b1;
            end
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        tv_next        = tv_reg;
        fs_next        = fs_reg;
        irq_next       = irq_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            tv_next        = count_reg;
            fs_next        = seen_reg;
            irq_next       = pend_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            count_reg     <= '0;
            pre_reg       <= '0;
            mode_reg      <= MODE_STOP;
            last_reg      <= 1'b0;
            flag_reg      <= 1'b0;
            ien_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            pre_reg       <= pre_next;
            mode_reg      <= mode_next;
            last_reg      <= last_next;
            flag_reg      <= flag_next;
            ien_reg       <= ien_next;
            pend_reg      <= pend_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        cyc_reg  <= cyc_next;
        samp_reg <= samp_next;
        load_reg <= load_next;
        tv_reg   <= tv_next;
        fs_reg   <= fs_next;
        irq_reg  <= irq_next;
    end

    assign out_valid   = out_valid_reg;
    assign timer_value = tv_reg;
    assign flag_seen   = fs_reg;
    assign irq_request = irq_reg;

    `ASSERT_IMPLIES(a_step_bound, state_reg == ST_RUN, step_reg <= cyc_reg)
    `ASSERT_NEXT(a_accept_runs, in_valid && in_ready, state_reg == ST_RUN)
    `ASSERT_HOLDS(a_pend_needs_en, !pend_reg || ien_reg)
    `ASSERT_NEXT(a_done_loads, state_reg == ST_DONE && state_next == ST_IDLE, out_valid_reg)

endmodule

>>> dv/tb_prescaled_timer_event_counter.sv
`timescale 1ns / 1ps
// Self-checking testbench for prescaled_timer_event_counter: directed command table, then
// weighted random command streams, checked against typed table expectations or an in-bench timer/counter predictor.
// Depends on ptec_pkg and the prescaled_timer_event_counter RTL.
module tb_prescaled_timer_event_counter
    import ptec_pkg::*;
();

    localparam int MAX_TICK      = 8;
    localparam int RANDOM_ITEMS  = 1425;
    localparam int CALM_ITEMS    = 200;
    localparam int STALL_LIMIT   = 1000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int DIRECTED_ROWS = 25;

    // command codes the block does not define; it treats them as a read
    localparam logic [3:0] CMD_UNUSED_LO = 4'hA;
    localparam logic [3:0] CMD_UNUSED_HI = 4'hF;

    typedef struct packed {
        logic [7:0] timer_value;
        logic       flag_seen;
        logic       irq_request;
    } timer_result_t;

    typedef struct {
        logic [3:0]    op;
        logic [3:0]    cycles;
        logic [7:0]    samples;
        logic [7:0]    load;
        bit            typed;
        timer_result_t result;
    } command_row_t;

    logic       clk;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    logic [3:0] cmd         = '0;
    logic [3:0] tick_cycles = '0;
    logic [7:0] t1_samples  = '0;
    logic [7:0] load_value  = '0;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    logic [7:0] timer_value;
    logic       flag_seen;
    logic       irq_request;

    // expectation typed into the table travels with the command it belongs to
    bit            row_typed  = 1'b0;
    timer_result_t row_result = '0;

    timer_result_t pending_results[$];
    int            error_count  = 0;
    int            stuck_cycles = 0;
    bit            idle_allowed = 1'b1;
    int            stall_left   = 0;

    // predicted timer state
    logic [7:0] model_count;
    logic [4:0] model_prescale;
    mode_t      model_mode;
    logic       model_last_pin;
    logic       model_flag;
    logic       model_irq_en;
    logic       model_irq_pend;

    command_row_t directed_rows [DIRECTED_ROWS] = '{
        '{CMD_READ,          4'd0,  8'h00, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
        '{CMD_TEST_CLEAR,    4'd0,  8'h00, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
        '{CMD_IRQ_ENABLE,    4'd0,  8'h00, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
        '{CMD_LOAD,          4'd0,  8'h00, 8'hFF, 1'b1, '{8'hFF, 1'b0, 1'b0}},
        '{CMD_START_TIMER,   4'd0,  8'h00, 8'h00, 1'b1, '{8'hFF, 1'b0, 1'b0}},
        '{CMD_TICK,          4'd15, 8'hFF, 8'hFF, 1'b1, '{8'hFF, 1'b0, 1'b0}},
        '{CMD_TICK,          4'd8,  8'h00, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{CMD_TICK,          4'd8,  8'h00, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{CMD_TICK,          4'd8,  8'h00, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b1}},
        '{CMD_TEST_CLEAR,    4'd0,  8'h00, 8'h00, 1'b1, '{8'h00, 1'b1, 1'b1}},
        '{CMD_IRQ_TAKEN,     4'd0,  8'h00, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
        '{CMD_LOAD,          4'd0,  8'h00, 8'hFE, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{CMD_START_COUNTER, 4'd0,  8'h01, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{CMD_TICK,          4'd8,  8'h55, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{CMD_START_COUNTER, 4'd0,  8'h00, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{CMD_TICK,          4'd12, 8'h80, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{CMD_TICK,          4'd0,  8'h00, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{CMD_IRQ_DISABLE,   4'd0,  8'h00, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{CMD_STOP,          4'd0,  8'h00, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{CMD_TICK,          4'd8,  8'hAA, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{CMD_START_TIMER,   4'd0,  8'h00, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{CMD_TICK,          4'd7,  8'h00, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{CMD_UNUSED_LO,     4'd9,  8'h3C, 8'h5A, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{CMD_UNUSED_HI,     4'd15, 8'hFF, 8'hFF, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{CMD_LOAD,          4'd15, 8'hFF, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}}
    };

    prescaled_timer_event_counter #(
        .MAX_TICK (MAX_TICK)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .tick_cycles (tick_cycles),
        .t1_samples  (t1_samples),
        .load_value  (load_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .timer_value (timer_value),
        .flag_seen   (flag_seen),
        .irq_request (irq_request)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Execute one command on the predicted state and return the result it gives.
    task automatic predict_timer_command(input logic [3:0] op, input logic [3:0] cycles,
                                         input logic [7:0] samples, input logic [7:0] load,
                                         output timer_result_t res);
        int         steps;
        int         pos;
        logic       level;
        logic       wrapped;
        logic       seen;
        logic [5:0] sum;
        logic [7:0] prior;
        wrapped = 1'b0;
        seen    = 1'b0;
        case (op)
            CMD_TICK:
            begin
                steps = (cycles > MAX_TICK) ? MAX_TICK : int'(cycles);
                if (model_mode == MODE_TIMER)
                begin
                    sum            = {1'b0, model_prescale} + 6'(steps);
                    prior          = model_count;
                    model_count    = model_count + 8'(sum[5]);
                    model_prescale = sum[4:0];
                    wrapped        = (prior != 8'd0) && (model_count == 8'd0);
                end
                else if (model_mode == MODE_COUNTER)
                begin
                    for (pos = 0; pos < steps; pos++)
                    begin
                        // cycles past the eighth hold the last sampled level
                        level = samples[(pos < 8) ? pos : 7];
                        if (model_last_pin && !level)
                        begin
                            model_count = model_count + 8'd1;
                            if (model_count == 8'd0)
                                wrapped = 1'b1;
                        end
                        model_last_pin = level;
                    end
                end
                if (wrapped)
                begin
                    model_flag = 1'b1;
                    if (model_irq_en)
                        model_irq_pend = 1'b1;
                end
            end
            CMD_START_TIMER:
            begin
                model_mode     = MODE_TIMER;
                model_prescale = '0;
            end
            CMD_START_COUNTER:
            begin
                if (model_mode != MODE_COUNTER)
                    model_last_pin = samples[0];
                model_mode = MODE_COUNTER;
            end
            CMD_STOP:        model_mode = MODE_STOP;
            CMD_LOAD:        model_count = load;
            CMD_TEST_CLEAR:
            begin
                seen       = model_flag;
                model_flag = 1'b0;
            end
            CMD_IRQ_ENABLE:  model_irq_en = 1'b1;
            CMD_IRQ_DISABLE:
            begin
                model_irq_en   = 1'b0;
                model_irq_pend = 1'b0;
            end
            CMD_IRQ_TAKEN:   model_irq_pend = 1'b0;
            default:         ;
        endcase
        res = '{model_count, seen, model_irq_pend};
    endtask

    // Present one command and hold it until the block takes it.
    task automatic send_command(input logic [3:0] op, input logic [3:0] cycles,
                                input logic [7:0] samples, input logic [7:0] load,
                                input bit typed, input timer_result_t typed_res);
        int gap;
        @(negedge clk);
        if (idle_allowed && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= op;
        tick_cycles <= cycles;
        t1_samples  <= samples;
        load_value  <= load;
        row_typed   <= typed;
        row_result  <= typed_res;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Result side backpressure: random stall bursts while idling is allowed.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (idle_allowed && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 6) - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin : transfer_monitor
        timer_result_t got;
        timer_result_t want;
        timer_result_t pred;
        if (rst_n)
        begin
            // retire the result first: it always belongs to an older command
            if (out_valid && out_ready)
            begin
                got = '{timer_value, flag_seen, irq_request};
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result: timer_value %0h flag_seen %0b irq_request %0b",
                           got.timer_value, got.flag_seen, got.irq_request);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.timer_value !== want.timer_value)
                    begin
                        $error("timer_value: expected %0h, got %0h",
                               want.timer_value, got.timer_value);
                        error_count++;
                    end
                    if (got.flag_seen !== want.flag_seen)
                    begin
                        $error("flag_seen: expected %0b, got %0b",
                               want.flag_seen, got.flag_seen);
                        error_count++;
                    end
                    if (got.irq_request !== want.irq_request)
                    begin
                        $error("irq_request: expected %0b, got %0b",
                               want.irq_request, got.irq_request);
                        error_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                predict_timer_command(cmd, tick_cycles, t1_samples, load_value, pred);
                pending_results.push_back(row_typed ? row_result : pred);
            end
            if ((out_valid && out_ready) || (in_valid && in_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
    end

    initial
    begin
        wait (stuck_cycles >= STALL_LIMIT);
        $display("tb_prescaled_timer_event_counter: done, errors");
        $finish;
    end

    initial
    begin
        int         idx;
        int         pick;
        logic [3:0] op;
        logic [3:0] cycles;
        logic [7:0] samples;
        logic [7:0] load;

        model_count    = '0;
        model_prescale = '0;
        model_mode     = MODE_STOP;
        model_last_pin = 1'b0;
        model_flag     = 1'b0;
        model_irq_en   = 1'b0;
        model_irq_pend = 1'b0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (idx = 0; idx < DIRECTED_ROWS; idx++)
            send_command(directed_rows[idx].op, directed_rows[idx].cycles,
                         directed_rows[idx].samples, directed_rows[idx].load,
                         directed_rows[idx].typed, directed_rows[idx].result);

        for (idx = 0; idx < RANDOM_ITEMS; idx++)
        begin
            // every third block of 64 runs without idling; the tail runs flat out
            idle_allowed = (idx < RANDOM_ITEMS - CALM_ITEMS) && ((idx / 64) % 3 != 2);
            pick    = $urandom_range(0, 99);
            cycles  = 4'($urandom_range(0, 15));
            samples = 8'($urandom);
            load    = 8'($urandom);
            if (pick < 46)
            begin
                op = CMD_TICK;
                if ($urandom_range(0, 4) != 0)
                    cycles = 4'($urandom_range(1, MAX_TICK));
            end
            else if (pick < 52)
                op = CMD_START_TIMER;
            else if (pick < 58)
                op = CMD_START_COUNTER;
            else if (pick < 61)
                op = CMD_STOP;
            else if (pick < 70)
            begin
                op = CMD_LOAD;
                // bias loads toward the top so wraps come often
                if ($urandom_range(0, 3) != 0)
                    load = 8'($urandom_range(8'hE0, 8'hFF));
            end
            else if (pick < 75)
                op = CMD_READ;
            else if (pick < 82)
                op = CMD_TEST_CLEAR;
            else if (pick < 87)
                op = CMD_IRQ_ENABLE;
            else if (pick < 91)
                op = CMD_IRQ_DISABLE;
            else if (pick < 96)
                op = CMD_IRQ_TAKEN;
            else
                op = 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
            send_command(op, cycles, samples, load, 1'b0, '0);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("tb_prescaled_timer_event_counter: done, clean");
        else
            $display("tb_prescaled_timer_event_counter: done, errors");
        $finish;
    end

endmodule
